>>> rtl/wcs_pkg.sv
// wcs_pkg: shared types and constants for the wrap cycle sequencer
// no dependencies
package wcs_pkg;

    localparam int PHASE_TIMER_BITS = 17;
    localparam int NUM_SENSORS      = 5;

    // sensor slots
    localparam int SN_DENS  = 0;
    localparam int SN_START = 1;
    localparam int SN_END   = 2;
    localparam int SN_DOOR  = 3;
    localparam int SN_BTN   = 4;

    typedef enum logic [3:0] {
        PH_DENSITY = 4'd0,
        PH_TRACTOR = 4'd1,
        PH_START   = 4'd2,
        PH_RUNNING = 4'd3,
        PH_END     = 4'd4,
        PH_DOOR    = 4'd5,
        PH_ERROR   = 4'd6,
        PH_TEST    = 4'd7,
        PH_HOME    = 4'd8
    } phase_t;

    typedef enum logic [1:0] {
        BEACON_OFF  = 2'd0,
        BEACON_ON   = 2'd1,
        BEACON_FAST = 2'd2,
        BEACON_SLOW = 2'd3
    } beacon_t;

    typedef enum logic [2:0] {
        CFG_DENSITY_HOLD  = 3'd0,
        CFG_STOP_DELAY    = 3'd1,
        CFG_NET_RUN       = 3'd2,
        CFG_TWINE_RUN     = 3'd3,
        CFG_MOTOR_TIMEOUT = 3'd4,
        CFG_SOUND_MODE    = 3'd5,
        CFG_DEBOUNCE      = 3'd6
    } cfg_idx_t;

    // checkpoint values
    localparam logic [1:0] CP_EMPTY    = 2'd0;
    localparam logic [1:0] CP_WRAPPING = 2'd1;
    localparam logic [1:0] CP_READY    = 2'd2;

    localparam int MS_PER_S        = 1000;
    localparam int TEST_HOLD_MS    = 10000;
    localparam int CLICK_GAP_MAX   = 600;
    localparam int TEST_TIMEOUT_MS = 60000;
    localparam int ERROR_BEEP_MS   = 4000;

    // input word layout
    typedef struct packed {
        logic remote_reset;
        logic remote_net_select;
        logic remote_manual;
        logic remote_connected;
        logic local_net_select;
        logic button_raw;
        logic door_raw;
        logic end_raw;
        logic start_raw;
        logic density_raw;
    } in_word_t;

    // debounced sensor status handed to the sequencer
    typedef struct packed {
        logic [NUM_SENSORS-1:0] stable;
        logic [NUM_SENSORS-1:0] pressed;
        logic                   dens_hold_1s;
        logic                   dens_hold_cfg;
        logic                   btn_hold_test;
    } sens_t;

    typedef struct packed {
        logic [4:0] density_hold_s;
        logic [4:0] stop_delay_s;
        logic [4:0] net_run_s;
        logic [4:0] twine_run_s;
        logic [6:0] motor_timeout_s;
        logic [1:0] sound_mode;
        logic [9:0] debounce_ms;
    } cfg_t;

    typedef struct packed {
        logic [1:0] beacon_mode;
        logic [2:0] beep_count;
        logic [9:0] beep_ms;
        logic       checkpoint_write;
        logic [1:0] checkpoint_value;
        logic       bale_done;
        logic       net_motor_on;
        logic       twine_motor_on;
        logic [3:0] phase;
    } out_word_t;

endpackage

>>> rtl/wcs_debounce.sv
// wcs_debounce: debounce and hold timers for the five sensors
// depends on wcs_pkg
module wcs_debounce (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               tick,
    input  logic [4:0]         raw,
    input  wcs_pkg::cfg_t      cfg,
    output wcs_pkg::sens_t     sens
);
    import wcs_pkg::*;

    logic [NUM_SENSORS-1:0] last_reg, last_next;
    logic [NUM_SENSORS-1:0] stable_reg, stable_next;
    logic [9:0]  steady_reg [NUM_SENSORS];
    logic [9:0]  steady_next [NUM_SENSORS];
    logic [14:0] held_reg [NUM_SENSORS];
    logic [14:0] held_next [NUM_SENSORS];
    logic [NUM_SENSORS-1:0] pressed;
    logic [16:0] dens_lim;

    // per sensor debounce, independent lanes
    always_comb begin
        for (int s = 0; s < NUM_SENSORS; s++) begin
            held_next[s] = (held_reg[s] == 15'h7fff) ? held_reg[s] : held_reg[s] + 15'd1;
            if (raw[s] != last_reg[s])
                steady_next[s] = '0;
            else
                steady_next[s] = (steady_reg[s] == 10'h3ff) ? steady_reg[s]
                                                             : steady_reg[s] + 10'd1;
            stable_next[s] = stable_reg[s];
            pressed[s] = 1'b0;
            if (steady_next[s] >= cfg.debounce_ms && stable_reg[s] != raw[s]) begin
                stable_next[s] = raw[s];
                held_next[s] = '0;
                pressed[s] = raw[s];
            end
            last_next[s] = raw[s];
        end
    end

    assign dens_lim = 17'(cfg.density_hold_s) * 17'(MS_PER_S);

    // hold comparisons against updated timers
    always_comb begin
        sens.stable        = stable_next;
        sens.pressed       = pressed;
        sens.dens_hold_1s  = stable_next[SN_DENS] && (held_next[SN_DENS] >= 15'(MS_PER_S));
        sens.dens_hold_cfg = stable_next[SN_DENS] && (17'(held_next[SN_DENS]) >= dens_lim);
        sens.btn_hold_test = stable_next[SN_BTN] && (held_next[SN_BTN] >= 15'(TEST_HOLD_MS));
    end

    // timer registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_reg   <= '0;
            stable_reg <= '0;
            for (int s = 0; s < NUM_SENSORS; s++) begin
                steady_reg[s] <= '0;
                held_reg[s]   <= '0;
            end
        end else if (tick) begin
            last_reg   <= last_next;
            stable_reg <= stable_next;
            for (int s = 0; s < NUM_SENSORS; s++) begin
                steady_reg[s] <= steady_next[s];
                held_reg[s]   <= held_next[s];
            end
        end
    end

endmodule

>>> rtl/wcs_sequencer.sv
// wcs_sequencer: wrap cycle phase machine, resets, test mode and clicks
// depends on wcs_pkg
module wcs_sequencer (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 tick,
    input  wcs_pkg::in_word_t    in_word,
    input  wcs_pkg::sens_t       sens,
    input  wcs_pkg::cfg_t        cfg,
    output wcs_pkg::out_word_t   res
);
    import wcs_pkg::*;

    localparam logic [PHASE_TIMER_BITS-1:0] PMAX = '1;

    phase_t  phase_reg, phase_next;
    logic [PHASE_TIMER_BITS-1:0] ptimer_reg, ptimer_next;
    logic [15:0] ttimer_reg, ttimer_next;
    logic        door_seen_reg, door_seen_next;
    logic [2:0]  clicks_reg, clicks_next;
    logic [9:0]  gap_reg, gap_next;
    logic [1:0]  relays_reg, relays_next;
    beacon_t     beacon_reg, beacon_next;

    logic [16:0] stop_lim, run_lim, tmo_lim;
    logic        conn, manual, net_sel, quiet;

    assign conn     = in_word.remote_connected;
    assign manual   = conn && in_word.remote_manual;
    assign net_sel  = conn ? in_word.remote_net_select : in_word.local_net_select;
    assign quiet    = conn && (cfg.sound_mode == 2'd1);
    assign stop_lim = 17'(cfg.stop_delay_s) * 17'(MS_PER_S);
    assign run_lim  = 17'(net_sel ? cfg.net_run_s : cfg.twine_run_s) * 17'(MS_PER_S);
    assign tmo_lim  = 17'(cfg.motor_timeout_s) * 17'(MS_PER_S);

    // next state in the order of checks of one tick
    always_comb begin
        logic [2:0] bc;
        logic [9:0] bm;
        logic       cpw, bale, tmo_hit;
        logic [1:0] cpv;
        logic [1:0] start_relay;

        bc = '0; bm = '0; cpw = 1'b0; cpv = CP_EMPTY; bale = 1'b0;
        start_relay = net_sel ? 2'b10 : 2'b01;
        phase_next     = phase_reg;
        ptimer_next    = (ptimer_reg == PMAX) ? ptimer_reg : ptimer_reg + 1'b1;
        ttimer_next    = (ttimer_reg == 16'hffff) ? ttimer_reg : ttimer_reg + 16'd1;
        gap_next       = (gap_reg == 10'h3ff) ? gap_reg : gap_reg + 10'd1;
        door_seen_next = door_seen_reg;
        clicks_next    = clicks_reg;
        relays_next    = relays_reg;
        beacon_next    = beacon_reg;

        // remote emergency reset
        if (in_word.remote_reset && phase_next != PH_DENSITY && phase_next != PH_TEST) begin
            relays_next = '0;
            if (!quiet) begin bc = 3'd1; bm = 10'd600; end
            beacon_next = BEACON_OFF; door_seen_next = sens.stable[SN_DOOR];
            clicks_next = '0; phase_next = PH_DENSITY; cpw = 1'b1; cpv = CP_EMPTY;
        end

        // long button hold into test mode
        if (sens.btn_hold_test && phase_next != PH_TEST) begin
            relays_next = '0;
            if (!quiet) begin bc = 3'd1; bm = 10'd100; end
            beacon_next = BEACON_SLOW; phase_next = PH_TEST;
            ttimer_next = '0; clicks_next = '0;
        end

        // button clicks
        if (sens.pressed[SN_BTN] && phase_next != PH_TEST) begin
            clicks_next = (gap_next <= 10'(CLICK_GAP_MAX))
                        ? ((clicks_next == 3'd7) ? clicks_next : clicks_next + 3'd1) : 3'd1;
            gap_next = '0;
            if (phase_next != PH_DENSITY && phase_next != PH_HOME) begin
                relays_next = '0;
                if (!quiet) begin bc = 3'd1; bm = 10'd600; end
                beacon_next = BEACON_OFF; door_seen_next = sens.stable[SN_DOOR];
                clicks_next = '0; phase_next = PH_DENSITY; cpw = 1'b1; cpv = CP_EMPTY;
            end else if (phase_next == PH_HOME) begin
                relays_next = '0;
                if (!quiet) begin bc = 3'd1; bm = 10'd600; end
                beacon_next = BEACON_OFF; phase_next = PH_DENSITY;
            end
            if (clicks_next == 3'd5 && phase_next == PH_DENSITY) begin
                clicks_next = '0; relays_next = relays_next | start_relay;
                if (!quiet) begin bc = 3'd1; bm = 10'd800; end
                beacon_next = BEACON_ON; ptimer_next = '0; phase_next = PH_HOME;
            end
        end

        // door opened outside unload, test and density
        if (sens.pressed[SN_DOOR] && phase_next != PH_DOOR && phase_next != PH_TEST &&
            phase_next != PH_DENSITY) begin
            relays_next = '0;
            if (!quiet) begin bc = 3'd1; bm = 10'd600; end
            beacon_next = BEACON_OFF; door_seen_next = sens.stable[SN_DOOR];
            clicks_next = '0; phase_next = PH_DENSITY; cpw = 1'b1; cpv = CP_EMPTY;
        end

        // motor timeout against the phase timer as the checks above left it
        tmo_hit = (cfg.motor_timeout_s != '0) && (PHASE_TIMER_BITS'(tmo_lim) <= ptimer_next);

        // phase work
        case (phase_next)
            PH_DENSITY: begin
                if (manual ? sens.dens_hold_1s : sens.dens_hold_cfg) begin
                    if (!quiet) begin bc = 3'd3; bm = 10'd300; end
                    beacon_next = BEACON_ON; ptimer_next = '0; phase_next = PH_TRACTOR;
                end
            end
            PH_TRACTOR: begin
                if (manual) begin
                    if (sens.stable[SN_START]) begin
                        if (!quiet) begin bc = 3'd1; bm = 10'd200; end
                        ptimer_next = '0; cpw = 1'b1; cpv = CP_WRAPPING;
                        phase_next = PH_RUNNING;
                    end
                end else if (PHASE_TIMER_BITS'(stop_lim) <= ptimer_next) begin
                    relays_next = relays_next | start_relay;
                    ptimer_next = '0; cpw = 1'b1; cpv = CP_WRAPPING; phase_next = PH_START;
                end
            end
            PH_START: begin
                if (sens.stable[SN_START]) begin
                    if (!quiet) begin bc = 3'd1; bm = 10'd200; end
                    ptimer_next = '0; phase_next = PH_RUNNING;
                end else if (tmo_hit) begin
                    relays_next = '0; beacon_next = BEACON_FAST;
                    ptimer_next = '0; phase_next = PH_ERROR;
                end
            end
            PH_RUNNING: begin
                if (PHASE_TIMER_BITS'(run_lim) <= ptimer_next) begin
                    relays_next = '0; ptimer_next = '0; phase_next = PH_END;
                end
            end
            PH_END: begin
                if (sens.stable[SN_END]) begin
                    if (!quiet) begin bc = 3'd2; bm = 10'd400; end
                    door_seen_next = 1'b0; cpw = 1'b1; cpv = CP_READY; phase_next = PH_DOOR;
                end else if (tmo_hit) begin
                    beacon_next = BEACON_FAST; ptimer_next = '0; phase_next = PH_ERROR;
                end
            end
            PH_DOOR: begin
                if (sens.stable[SN_DOOR] && !door_seen_next) begin
                    door_seen_next = 1'b1;
                end else if (!sens.stable[SN_DOOR] && door_seen_next) begin
                    cpw = 1'b1; cpv = CP_EMPTY;
                    if (!quiet) begin bc = 3'd2; bm = 10'd150; end
                    bale = 1'b1; door_seen_next = 1'b0; beacon_next = BEACON_OFF;
                    phase_next = PH_DENSITY;
                end
            end
            PH_ERROR: begin
                if (PHASE_TIMER_BITS'(ERROR_BEEP_MS) <= ptimer_next) begin
                    if (!quiet) begin bc = 3'd2; bm = 10'd200; end
                    ptimer_next = '0;
                end
            end
            PH_HOME: begin
                if (sens.stable[SN_END]) begin
                    relays_next = '0;
                    if (!quiet) begin bc = 3'd2; bm = 10'd400; end
                    beacon_next = BEACON_OFF; phase_next = PH_DENSITY;
                end else if (tmo_hit) begin
                    relays_next = '0; beacon_next = BEACON_FAST;
                    ptimer_next = '0; phase_next = PH_ERROR;
                end
            end
            PH_TEST: begin
                if (ttimer_next >= 16'(TEST_TIMEOUT_MS)) begin
                    if (!quiet) begin bc = 3'd2; bm = 10'd400; end
                    beacon_next = BEACON_OFF; door_seen_next = sens.stable[SN_DOOR];
                    phase_next = PH_DENSITY;
                end
            end
            default: ;
        endcase

        res.phase            = phase_next;
        res.twine_motor_on   = relays_next[0];
        res.net_motor_on     = relays_next[1];
        res.beacon_mode      = beacon_next;
        res.beep_count       = bc;
        res.beep_ms          = bm;
        res.checkpoint_write = cpw;
        res.checkpoint_value = cpw ? cpv : CP_EMPTY;
        res.bale_done        = bale;
    end

    // sequencer state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_DENSITY;
            ptimer_reg    <= '0;
            ttimer_reg    <= '0;
            door_seen_reg <= 1'b0;
            clicks_reg    <= '0;
            gap_reg       <= '1;
            relays_reg    <= '0;
            beacon_reg    <= BEACON_OFF;
        end else if (tick) begin
            phase_reg     <= phase_next;
            ptimer_reg    <= ptimer_next;
            ttimer_reg    <= ttimer_next;
            door_seen_reg <= door_seen_next;
            clicks_reg    <= clicks_next;
            gap_reg       <= gap_next;
            relays_reg    <= relays_next;
            beacon_reg    <= beacon_next;
        end
    end

    // net and twine relays are never driven together
    a_relays_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        !(relays_reg[0] && relays_reg[1]))
        else $error("both relays on");
    // bale done only leaves the unload phase
    a_bale_from_door: assert property (@(posedge aclk) disable iff (!aresetn)
        (tick && res.bale_done) |-> (phase_reg == PH_DOOR))
        else $error("bale pulse outside unload");
    // error phase keeps motors off
    a_error_motors_off: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_ERROR) |-> (relays_reg == 2'b00))
        else $error("motor on in error phase");

endmodule

>>> rtl/wrap_cycle_sequencer.sv
// wrap_cycle_sequencer: top level with config registers, input and result stages
// depends on wcs_pkg, wcs_debounce, wcs_sequencer
//
// One input word is one millisecond tick; one result word comes out per tick. A word is taken
// every clock cycle while the result side keeps up: the tick's whole update is combinational
// logic between the input word register and the result register, so throughput is one word
// per cycle. The result register with its skid slot lets s_axis_tready stay high while one
// finished word waits.
module wrap_cycle_sequencer (
    input  logic        aclk,
    input  logic        aresetn,
    // tdata: density_raw, start_raw, end_raw, door_raw, button_raw, local_net_select,
    //        remote_connected, remote_manual, remote_net_select, remote_reset, 6 zero bits
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,
    // tdata: phase[3:0], twine_motor_on, net_motor_on, beacon_mode[1:0], beep_count[2:0],
    //        beep_ms[9:0], checkpoint_write, checkpoint_value[1:0], bale_done, 7 zero bits
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [9:0]  cfg_data
);
    import wcs_pkg::*;

    cfg_t      cfg_reg;
    in_word_t  in_reg;
    logic      in_vld_reg;
    out_word_t res;
    out_word_t out_reg, skid_reg;
    logic      out_vld_reg, skid_vld_reg;
    sens_t     sens;
    logic      tick;

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = !skid_vld_reg;
    assign tick          = in_vld_reg && !skid_vld_reg;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.density_hold_s  <= 5'd1;
            cfg_reg.stop_delay_s    <= 5'd4;
            cfg_reg.net_run_s       <= 5'd2;
            cfg_reg.twine_run_s     <= 5'd3;
            cfg_reg.motor_timeout_s <= 7'd40;
            cfg_reg.sound_mode      <= 2'd2;
            cfg_reg.debounce_ms     <= 10'd150;
        end else if (cfg_valid) begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_DENSITY_HOLD:  cfg_reg.density_hold_s  <= cfg_data[4:0];
                CFG_STOP_DELAY:    cfg_reg.stop_delay_s    <= cfg_data[4:0];
                CFG_NET_RUN:       cfg_reg.net_run_s       <= cfg_data[4:0];
                CFG_TWINE_RUN:     cfg_reg.twine_run_s     <= cfg_data[4:0];
                CFG_MOTOR_TIMEOUT: cfg_reg.motor_timeout_s <= cfg_data[6:0];
                CFG_SOUND_MODE:    cfg_reg.sound_mode      <= cfg_data[1:0];
                CFG_DEBOUNCE:      cfg_reg.debounce_ms     <= cfg_data;
                default: ;
            endcase
        end
    end

    // input word register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_axis_tready) begin
            in_vld_reg <= s_axis_tvalid;
        end
        if (s_axis_tready && s_axis_tvalid)
            in_reg <= in_word_t'(s_axis_tdata[9:0]);
    end

    wcs_debounce u_deb (
        .aclk    (aclk),
        .aresetn (aresetn),
        .tick    (tick),
        .raw     ({in_reg.button_raw, in_reg.door_raw, in_reg.end_raw,
                   in_reg.start_raw, in_reg.density_raw}),
        .cfg     (cfg_reg),
        .sens    (sens)
    );

    wcs_sequencer u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .tick    (tick),
        .in_word (in_reg),
        .sens    (sens),
        .cfg     (cfg_reg),
        .res     (res)
    );

    // result register with skid slot
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end else begin
            if (!out_vld_reg || m_axis_tready) begin
                if (skid_vld_reg) begin
                    out_reg      <= skid_reg;
                    out_vld_reg  <= 1'b1;
                    skid_vld_reg <= 1'b0;
                end else begin
                    out_vld_reg <= tick;
                    if (tick) out_reg <= res;
                end
            end else if (tick) begin
                skid_reg     <= res;
                skid_vld_reg <= 1'b1;
            end
        end
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = {7'd0, out_reg.bale_done, out_reg.checkpoint_value,
                            out_reg.checkpoint_write, out_reg.beep_ms, out_reg.beep_count,
                            out_reg.beacon_mode, out_reg.net_motor_on,
                            out_reg.twine_motor_on, out_reg.phase};

endmodule

>>> tb/tb_top.sv
// tb_top: self-checking bench for the wrap cycle sequencer, one tick word in, one result word out
// depends on wcs_pkg and wrap_cycle_sequencer; holds its own tick-by-tick predictor
`timescale 1ns / 1ps

module tb_top;
    import wcs_pkg::*;

    // input word bit masks, density_raw in the lowest bit
    localparam logic [9:0] IN_DENS  = 10'h001;
    localparam logic [9:0] IN_START = 10'h002;
    localparam logic [9:0] IN_END   = 10'h004;
    localparam logic [9:0] IN_DOOR  = 10'h008;
    localparam logic [9:0] IN_BTN   = 10'h010;
    localparam logic [9:0] IN_LNET  = 10'h020;
    localparam logic [9:0] IN_CONN  = 10'h040;
    localparam logic [9:0] IN_MAN   = 10'h080;
    localparam logic [9:0] IN_RNET  = 10'h100;
    localparam logic [9:0] IN_RRST  = 10'h200;
    localparam int unsigned PHASE_MAX   = (1 << PHASE_TIMER_BITS) - 1;
    localparam int          LONG_HOLD   = 400;
    localparam int          SETTLE_CYC  = 8;

    typedef struct packed {
        logic [3:0] phase;
        logic       twine_on;
        logic       net_on;
        logic [1:0] beacon;
        logic [2:0] beep_n;
        logic [9:0] beep_len;
        logic       cp_wr;
        logic [1:0] cp_val;
        logic       bale;
    } tick_result_t;

    typedef struct {
        logic [9:0]   bits;
        int           ticks;
        bit           typed;
        tick_result_t want;
    } tick_row_t;

    typedef struct {
        int unsigned dens_hold, stop_delay, net_run, twine_run, timeout, sound, debounce;
    } cfg_set_t;

    logic        aclk;
    logic        aresetn;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [9:0]  cfg_data;

    wrap_cycle_sequencer u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // predictor settings and state
    cfg_set_t    cur_cfg;
    phase_t      seq_phase;
    int unsigned phase_ms, test_ms, gap_ms, clicks, relays;
    logic [1:0]  beacon;
    bit          door_open_seen;
    int unsigned raw_prev[NUM_SENSORS], level[NUM_SENSORS];
    int unsigned steady[NUM_SENSORS], held[NUM_SENSORS];
    bit          rose[NUM_SENSORS];
    int unsigned beep_n, beep_len, cp_val;
    bit          cp_wr, link_up, net_remote, net_local;

    tick_result_t result_q[$];
    tick_row_t    rows[$];
    int           fail_count;
    bit           quiet;
    bit           long_hold_req;

    // clock and limit
    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        #20_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic int unsigned sat_inc(int unsigned v, int unsigned top);
        return (v >= top) ? top : v + 1;
    endfunction

    function void pred_reset();
        cur_cfg = '{1, 4, 2, 3, 40, 2, 150};
        seq_phase = PH_DENSITY;
        phase_ms = 0; test_ms = 0; gap_ms = 1023; clicks = 0; relays = 0;
        beacon = BEACON_OFF; door_open_seen = 0;
        for (int i = 0; i < NUM_SENSORS; i++) begin
            raw_prev[i] = 0; level[i] = 0; steady[i] = 0; held[i] = 0;
        end
    endfunction

    function void req_beep(int unsigned n, int unsigned ms);
        if (!(link_up && cur_cfg.sound == 1)) begin
            beep_n = n; beep_len = ms;
        end
    endfunction

    function void store_cp(int unsigned v);
        cp_wr = 1; cp_val = v;
    endfunction

    function bit net_chosen();
        return link_up ? net_remote : net_local;
    endfunction

    function void start_motor();
        relays |= net_chosen() ? 2 : 1;
    endfunction

    function bit held_long(int s, int unsigned ms);
        return level[s] != 0 && held[s] >= ms;
    endfunction

    function bit timed_out();
        return cur_cfg.timeout > 0 && phase_ms >= cur_cfg.timeout * MS_PER_S;
    endfunction

    function void abort_wrap();
        if (seq_phase != PH_DENSITY && seq_phase != PH_TEST) begin
            relays = 0; req_beep(1, 600); beacon = BEACON_OFF;
            door_open_seen = level[SN_DOOR] != 0;
            clicks = 0; seq_phase = PH_DENSITY;
            store_cp(CP_EMPTY);
        end
    endfunction

    // one millisecond tick of the sequencer
    function tick_result_t predict_tick(in_word_t w);
        tick_result_t r;
        bit manual, bale, click;
        int unsigned lim, raw;
        logic [9:0] b;
        b = w;
        link_up = w.remote_connected;
        manual = link_up && w.remote_manual;
        net_remote = w.remote_net_select;
        net_local = w.local_net_select;
        beep_n = 0; beep_len = 0; cp_wr = 0; cp_val = 0; bale = 0;

        phase_ms = sat_inc(phase_ms, PHASE_MAX);
        test_ms = sat_inc(test_ms, 65535);
        gap_ms = sat_inc(gap_ms, 1023);

        // debounce and hold time per sensor
        for (int s = 0; s < NUM_SENSORS; s++) begin
            raw = 32'(b[s]);
            held[s] = sat_inc(held[s], 32767);
            steady[s] = (raw != raw_prev[s]) ? 0 : sat_inc(steady[s], 1023);
            rose[s] = 0;
            if (steady[s] >= cur_cfg.debounce && level[s] != raw) begin
                level[s] = raw; held[s] = 0; rose[s] = raw != 0;
            end
            raw_prev[s] = raw;
        end

        if (w.remote_reset) abort_wrap();

        // button: long hold into test, clicks into return home
        click = rose[SN_BTN];
        if (held_long(SN_BTN, TEST_HOLD_MS) && seq_phase != PH_TEST) begin
            relays = 0; req_beep(1, 100); beacon = BEACON_SLOW;
            seq_phase = PH_TEST; test_ms = 0; clicks = 0;
        end
        if (click && seq_phase != PH_TEST) begin
            clicks = (gap_ms <= CLICK_GAP_MAX) ? sat_inc(clicks, 7) : 1;
            gap_ms = 0;
            if (seq_phase != PH_DENSITY && seq_phase != PH_HOME) abort_wrap();
            else if (seq_phase == PH_HOME) begin
                relays = 0; req_beep(1, 600); beacon = BEACON_OFF; seq_phase = PH_DENSITY;
            end
            if (clicks == 5 && seq_phase == PH_DENSITY) begin
                clicks = 0; start_motor(); req_beep(1, 800); beacon = BEACON_ON;
                phase_ms = 0; seq_phase = PH_HOME;
            end
        end

        if (rose[SN_DOOR] && seq_phase != PH_DOOR && seq_phase != PH_TEST) abort_wrap();

        case (seq_phase)
            PH_DENSITY: begin
                lim = manual ? MS_PER_S : cur_cfg.dens_hold * MS_PER_S;
                if (held_long(SN_DENS, lim)) begin
                    req_beep(3, 300); beacon = BEACON_ON; phase_ms = 0; seq_phase = PH_TRACTOR;
                end
            end
            PH_TRACTOR: begin
                if (manual) begin
                    if (level[SN_START] != 0) begin
                        req_beep(1, 200); phase_ms = 0; store_cp(CP_WRAPPING);
                        seq_phase = PH_RUNNING;
                    end
                end else if (phase_ms >= cur_cfg.stop_delay * MS_PER_S) begin
                    start_motor(); phase_ms = 0; store_cp(CP_WRAPPING); seq_phase = PH_START;
                end
            end
            PH_START: begin
                if (level[SN_START] != 0) begin
                    req_beep(1, 200); phase_ms = 0; seq_phase = PH_RUNNING;
                end else if (timed_out()) begin
                    relays = 0; beacon = BEACON_FAST; phase_ms = 0; seq_phase = PH_ERROR;
                end
            end
            PH_RUNNING: begin
                lim = (net_chosen() ? cur_cfg.net_run : cur_cfg.twine_run) * MS_PER_S;
                if (phase_ms >= lim) begin
                    relays = 0; phase_ms = 0; seq_phase = PH_END;
                end
            end
            PH_END: begin
                if (level[SN_END] != 0) begin
                    req_beep(2, 400); door_open_seen = 0; store_cp(CP_READY);
                    seq_phase = PH_DOOR;
                end else if (timed_out()) begin
                    beacon = BEACON_FAST; phase_ms = 0; seq_phase = PH_ERROR;
                end
            end
            PH_DOOR: begin
                if (level[SN_DOOR] != 0 && !door_open_seen) door_open_seen = 1;
                else if (level[SN_DOOR] == 0 && door_open_seen) begin
                    store_cp(CP_EMPTY); req_beep(2, 150); bale = 1;
                    door_open_seen = 0; beacon = BEACON_OFF; seq_phase = PH_DENSITY;
                end
            end
            PH_ERROR: begin
                if (phase_ms >= ERROR_BEEP_MS) begin
                    req_beep(2, 200); phase_ms = 0;
                end
            end
            PH_HOME: begin
                if (level[SN_END] != 0) begin
                    relays = 0; req_beep(2, 400); beacon = BEACON_OFF; seq_phase = PH_DENSITY;
                end else if (timed_out()) begin
                    relays = 0; beacon = BEACON_FAST; phase_ms = 0; seq_phase = PH_ERROR;
                end
            end
            PH_TEST: begin
                if (test_ms >= TEST_TIMEOUT_MS) begin
                    req_beep(2, 400); beacon = BEACON_OFF;
                    door_open_seen = level[SN_DOOR] != 0; seq_phase = PH_DENSITY;
                end
            end
            default: ;
        endcase

        r.phase = seq_phase;
        r.twine_on = relays[0];
        r.net_on = relays[1];
        r.beacon = beacon;
        r.beep_n = 3'(beep_n);
        r.beep_len = 10'(beep_len);
        r.cp_wr = cp_wr;
        r.cp_val = 2'(cp_val);
        r.bale = bale;
        return r;
    endfunction

    function int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 70) return 0;
        if (r < 96) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // offer one tick word and wait for it to be taken
    task send_tick(logic [9:0] bits);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {6'd0, bits};
        do @(posedge aclk); while (!s_axis_tready);
        result_q.push_back(predict_tick(in_word_t'(bits)));
    endtask

    // hold a level vector for a number of ticks; a remote reset lasts one tick only
    task hold_level(logic [9:0] bits, int ticks);
        for (int i = 0; i < ticks; i++) send_tick(i == 0 ? bits : (bits & ~IN_RRST));
    endtask

    // stop offering until every expected result has come out
    task drain();
        s_axis_tvalid <= 1'b0;
        do @(posedge aclk); while (result_q.size() != 0);
        repeat (SETTLE_CYC) @(posedge aclk);
    endtask

    task write_reg(cfg_idx_t idx, int unsigned val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val[9:0];
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task apply_cfg(cfg_set_t c);
        drain();
        write_reg(CFG_DENSITY_HOLD, c.dens_hold);
        write_reg(CFG_STOP_DELAY, c.stop_delay);
        write_reg(CFG_NET_RUN, c.net_run);
        write_reg(CFG_TWINE_RUN, c.twine_run);
        write_reg(CFG_MOTOR_TIMEOUT, c.timeout);
        write_reg(CFG_SOUND_MODE, c.sound);
        write_reg(CFG_DEBOUNCE, c.debounce);
        cur_cfg = c;
    endtask

    function logic [9:0] remote_bits();
        return 10'($urandom_range(0, 15) << 5);
    endfunction

    // one bale: density, start sensor, end sensor, door open and shut
    task bale_cycle();
        int db, run;
        logic [9:0] rb;
        db = cur_cfg.debounce;
        run = (cur_cfg.net_run > cur_cfg.twine_run) ? cur_cfg.net_run : cur_cfg.twine_run;
        rb = remote_bits();
        hold_level(IN_DENS | rb, cur_cfg.dens_hold * 1000 + db +
                   cur_cfg.stop_delay * 1000 + $urandom_range(0, 8));
        if ($urandom_range(0, 5) == 0) rb = remote_bits();
        hold_level(IN_DENS | IN_START | rb | ($urandom_range(0, 19) == 0 ? IN_RRST : 10'd0),
                   db + run * 1000 + $urandom_range(0, 6));
        hold_level(IN_END | rb, db + $urandom_range(2, 10));
        hold_level(IN_DOOR | rb, db + $urandom_range(2, 10));
        hold_level(rb, db + $urandom_range(2, 10));
    endtask

    task click_burst();
        int db, n;
        db = cur_cfg.debounce;
        n = $urandom_range(3, 7);
        for (int i = 0; i < n; i++) begin
            hold_level(IN_BTN, db + $urandom_range(1, 4));
            hold_level(10'd0, db + $urandom_range(1, 6));
        end
        hold_level(IN_END, db + $urandom_range(1, 5));
        hold_level(10'd0, db + 5);
    endtask

    task noise_run(int segs);
        for (int i = 0; i < segs; i++)
            hold_level(10'($urandom_range(0, 1023)) &
                       ($urandom_range(0, 7) == 0 ? 10'h3ff : 10'h1ff),
                       $urandom_range(1, 2 * cur_cfg.debounce + 8));
    endtask

    function void add_row(logic [9:0] bits, int ticks);
        rows.push_back('{bits, ticks, 1'b0, '0});
    endfunction

    // result check, field by field against the oldest expectation
    initial begin
        tick_result_t want, got;
        int stall;
        m_axis_tready = 1'b0;
        stall = 0;
        forever begin
            @(posedge aclk);
            if (m_axis_tvalid && m_axis_tready) begin
                got = {m_axis_tdata[3:0], m_axis_tdata[4], m_axis_tdata[5], m_axis_tdata[7:6],
                       m_axis_tdata[10:8], m_axis_tdata[20:11], m_axis_tdata[21],
                       m_axis_tdata[23:22], m_axis_tdata[24]};
                if (result_q.size() == 0) begin
                    $display("%0t: result word with nothing expected: %h", $time, m_axis_tdata);
                    fail_count++;
                end else begin
                    want = result_q.pop_front();
                    if (got.phase !== want.phase) begin
                        $display("%0t: phase exp %0d got %0d", $time, want.phase, got.phase);
                        fail_count++;
                    end
                    if (got.twine_on !== want.twine_on || got.net_on !== want.net_on) begin
                        $display("%0t: relays exp twine %0b net %0b got twine %0b net %0b",
                                 $time, want.twine_on, want.net_on, got.twine_on, got.net_on);
                        fail_count++;
                    end
                    if (got.beacon !== want.beacon) begin
                        $display("%0t: beacon exp %0d got %0d", $time, want.beacon, got.beacon);
                        fail_count++;
                    end
                    if (got.beep_n !== want.beep_n || got.beep_len !== want.beep_len) begin
                        $display("%0t: beep exp %0d x %0d ms got %0d x %0d ms", $time,
                                 want.beep_n, want.beep_len, got.beep_n, got.beep_len);
                        fail_count++;
                    end
                    if (got.cp_wr !== want.cp_wr || got.cp_val !== want.cp_val) begin
                        $display("%0t: checkpoint exp %0b/%0d got %0b/%0d", $time,
                                 want.cp_wr, want.cp_val, got.cp_wr, got.cp_val);
                        fail_count++;
                    end
                    if (got.bale !== want.bale) begin
                        $display("%0t: bale_done exp %0b got %0b", $time, want.bale, got.bale);
                        fail_count++;
                    end
                end
            end
            // result side back-pressure
            if (long_hold_req) begin
                long_hold_req = 0;
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
                m_axis_tready <= 1'b1;
            end else if (stall > 0) begin
                stall--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
                if (!quiet) begin
                    if ($urandom_range(0, 63) == 0) stall = $urandom_range(15, 60);
                    else if ($urandom_range(0, 7) == 0) stall = $urandom_range(1, 3);
                end
            end
        end
    end

    // main stimulus
    initial begin
        cfg_set_t sets[6];
        tick_row_t row;
        tick_result_t exp_r;
        aresetn = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_DENSITY_HOLD;
        cfg_data = '0;
        fail_count = 0;
        quiet = 0;
        long_hold_req = 0;
        pred_reset();
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // zero second timings keep whole cycles short in ticks
        sets[0] = '{0, 0, 0, 0, 0, 2, 1};
        sets[1] = '{0, 0, 0, 0, 40, 1, 3};
        sets[2] = '{0, 0, 0, 0, 1, 0, 2};
        sets[3] = '{0, 0, 0, 0, 90, 2, 6};
        sets[4] = '{0, 0, 0, 0, 127, 3, 0};
        sets[5] = '{0, 0, 0, 0, 0, 1, 1};

        // first ticks after reset, defaults still in force: an idle tick and a remote reset, all quiet
        rows.push_back('{10'd0, 1, 1'b1, '{PH_DENSITY, 1'b0, 1'b0, BEACON_OFF, 3'd0, 10'd0,
                                         1'b0, CP_EMPTY, 1'b0}});
        rows.push_back('{IN_RRST, 1, 1'b1, '{PH_DENSITY, 1'b0, 1'b0, BEACON_OFF, 3'd0, 10'd0,
                                          1'b0, CP_EMPTY, 1'b0}});
        foreach (rows[i]) begin
            row = rows[i];
            for (int t = 0; t < row.ticks; t++) send_tick(row.bits);
            exp_r = result_q[result_q.size() - 1];
            if (row.typed && exp_r !== row.want) begin
                $display("%0t: directed row %0d exp %h got prediction %h", $time, i,
                         row.want, exp_r);
                fail_count++;
            end
        end
        rows.delete();

        // directed walk: automatic cycle with remote abort, manual cycle to bale,
        // door abort, clicks to return home
        apply_cfg(sets[0]);
        add_row(IN_DENS, 4);
        add_row(IN_DENS | IN_START, 4);
        add_row(IN_DENS | IN_RRST, 1);
        add_row(10'd0, 5);
        add_row(IN_DENS, 2);
        add_row(IN_DENS | IN_START | IN_CONN | IN_MAN | IN_RNET, 6);
        add_row(IN_END | IN_CONN | IN_MAN | IN_RNET, 10);
        add_row(IN_DOOR | IN_CONN, 10);
        add_row(10'd0, 10);
        add_row(IN_DENS | IN_LNET, 12);
        add_row(IN_DENS | IN_DOOR | IN_LNET, 10);
        add_row(10'd0, 10);
        for (int k = 0; k < 5; k++) begin
            add_row(IN_BTN, 3);
            add_row(10'd0, 3);
        end
        add_row(IN_END, 5);
        add_row(10'd0, 5);
        foreach (rows[i])
            for (int t = 0; t < rows[i].ticks; t++) send_tick(rows[i].bits);

        // random part, one pass per register setting
        for (int p = 1; p < 6; p++) begin
            apply_cfg(sets[p]);
            quiet = (p == 4);
            if (p == 2) long_hold_req = 1;
            for (int c = 0; c < ((p == 3) ? 1 : 2); c++) begin
                bale_cycle();
                if ($urandom_range(0, 1) == 0) click_burst();
                if (p != 3) noise_run(2);
            end
            if (p == 2) drain();
        end
        quiet = 0;

        drain();
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

>>> files.f
rtl/wcs_pkg.sv
rtl/wcs_debounce.sv
rtl/wcs_sequencer.sv
rtl/wrap_cycle_sequencer.sv
tb/tb_top.sv
